// File: sv/array_priority_queue_unit_defines.svh
// Assertion helpers for the priority queue block.
// The using module must have clk_i and rst_ni in scope.
`ifndef ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`define APQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("array_priority_queue_unit: check failed");

`define APQ_ASSERT_NEVER(label, expr) \
  `APQ_ASSERT(label, !(expr))

`endif

// File: sv/apq_pkg.sv
package apq_pkg;

  localparam int unsigned KEY_IO_W = 32;
  localparam int unsigned CNT_IO_W = 7;
  localparam int unsigned CAP_W    = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_HIGH_MODE = 1'b0;
  localparam logic CFG_CAP_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

endpackage

// File: sv/apq_ram.sv
module apq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/array_priority_queue_unit.sv
// Channel  Direction  Handshake               Words
// in       input      in_valid_i / in_stall_o  cmd_i, key_in_i
// out      output     out_valid_o / out_stall_i key_out_o, status_o, count_o
// cfg      input      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// Insert, empty remove/peek and unused commands go straight to the finish
// state. Peek and remove first scan the queue: the single read port
// of the entry RAM scans one entry per cycle, then remove moves the entries
// behind the chosen one forward, one per cycle.
// Reset clears the count, state and output valid and loads the config defaults; the entry RAM needs no clearing.
// A new word is taken only when the previous one has been handed to the
// output register; the output register holds while out_stall_i is high.
`include "array_priority_queue_unit_defines.svh"

module array_priority_queue_unit import apq_pkg::*; #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [KEY_IO_W-1:0] key_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KEY_IO_W-1:0] key_out_o,
  output logic [1:0]          status_o,
  output logic [CNT_IO_W-1:0] count_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                high_mode_q;
  logic [CAP_W-1:0]    cap_q;
  logic [1:0]          cmd_q, cmd_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic [AW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [KEY_WIDTH-1:0] best_key_q, best_key_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic [AW-1:0]       sh_wr_q, sh_wr_d;
  logic                sh_pend_q, sh_pend_d;
  logic [KEY_WIDTH-1:0] res_key_q, res_key_d;
  logic [1:0]          res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [KEY_IO_W-1:0] out_key_q, out_key_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [CNT_IO_W-1:0] out_count_q, out_count_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                 in_acc;
  logic                 full;
  logic                 better, take, last;
  logic [KEY_WIDTH-1:0] scan_key;
  logic [AW-1:0]        scan_idx;
  logic [CMPW-1:0]      cnt_ext;

  apq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_ext    = CMPW'(cnt_q);
  assign full       = (cnt_ext >= CMPW'(cap_q)) || (cnt_q >= CW'(DEPTH));

  // Scan compare: strict compare keeps the oldest entry on ties.
  assign better   = high_mode_q ? (ram_rdata > best_key_q) : (ram_rdata < best_key_q);
  assign take     = (cmp_idx_q == '0) || better;
  assign scan_key = take ? ram_rdata : best_key_q;
  assign scan_idx = take ? cmp_idx_q : best_idx_q;
  assign last     = (CW'(cmp_idx_q) + CW'(1)) == cnt_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    best_key_d   = best_key_q;
    best_idx_d   = best_idx_q;
    sh_wr_d      = sh_wr_q;
    sh_pend_d    = sh_pend_q;
    res_key_d    = res_key_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_key_d    = out_key_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = KEY_WIDTH'(key_in_i);
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d        = cmd_i;
          res_key_d    = '0;
          res_status_d = ST_OK;
          state_d      = S_FINISH;
          case (cmd_i)
            CMD_INSERT: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                cnt_d     = cnt_q + CW'(1);
              end
            end
            CMD_REMOVE, CMD_PEEK: begin
              if (cnt_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_idx_d  = CW'(1);
                cmp_idx_d = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        best_key_d = scan_key;
        best_idx_d = scan_idx;
        cmp_idx_d  = cmp_idx_q + AW'(1);
        if (rd_idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        if (last) begin
          res_key_d = scan_key;
          if (cmd_q == CMD_REMOVE) begin
            rd_idx_d  = CW'(scan_idx) + CW'(1);
            sh_wr_d   = scan_idx;
            sh_pend_d = 1'b0;
            state_d   = S_SHIFT;
          end else begin
            state_d = S_FINISH;
          end
        end
      end

      S_SHIFT: begin
        // Entry rd_idx - 1 arrives from the read issued last cycle and moves
        // one place toward the front.
        if (sh_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wr_q;
          ram_wdata = ram_rdata;
          sh_wr_d   = sh_wr_q + AW'(1);
        end
        if (rd_idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
          sh_pend_d = 1'b1;
        end else begin
          sh_pend_d = 1'b0;
          if (!sh_pend_q) begin
            cnt_d   = cnt_q - CW'(1);
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_key_d    = KEY_IO_W'(res_key_q);
          out_status_d = res_status_q;
          out_count_d  = cnt_ext[CNT_IO_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      high_mode_q <= 1'b1;
      cap_q       <= CAP_W'(10);
      out_valid_q <= 1'b0;
      sh_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      sh_pend_q   <= sh_pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HIGH_MODE: high_mode_q <= cfg_wdata_i[0];
          CFG_CAP_LIMIT: cap_q       <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    best_key_q   <= best_key_d;
    best_idx_q   <= best_idx_d;
    sh_wr_q      <= sh_wr_d;
    res_key_q    <= res_key_d;
    res_status_q <= res_status_d;
    out_key_q    <= out_key_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = out_key_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

  `APQ_ASSERT_NEVER(a_count_in_range, cnt_q > CW'(DEPTH))
  `APQ_ASSERT(a_insert_grows,
    (in_acc && cmd_i == CMD_INSERT && !full) |=> cnt_q == $past(cnt_q) + CW'(1))
  `APQ_ASSERT(a_write_states, ram_we |-> (state_q == S_IDLE || state_q == S_SHIFT))
  `APQ_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == S_FINISH))

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import apq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          LONG_HOLD   = 400;
  localparam int          DRAIN_WAIT  = 140;

  typedef struct packed {
    logic [KEY_IO_W-1:0] key;
    logic [1:0]          status;
    logic [CNT_IO_W-1:0] count;
  } reply_t;

  // Tracks the keys the block should hold and the replies it owes.
  class queue_scoreboard;
    logic [KEY_IO_W-1:0] held_keys[$];
    reply_t              expected_replies[$];
    bit                  serve_largest = 1'b1;
    int unsigned         cap_limit = 10;
    int unsigned         failures = 0;

    function int unsigned room();
      return (cap_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_limit;
    endfunction

    function void note_config(logic idx, logic [CAP_W-1:0] data);
      if (idx == CFG_HIGH_MODE) begin
        serve_largest = data[0];
      end else begin
        cap_limit = 32'(data);
      end
    endfunction

    function void note_command(logic [1:0] cmd, logic [KEY_IO_W-1:0] key);
      reply_t r;
      int     top;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (held_keys.size() >= room()) begin
            r.status = ST_FULL;
          end else begin
            held_keys.push_back(key);
          end
        end
        CMD_REMOVE, CMD_PEEK: begin
          if (held_keys.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // Strict comparison keeps the oldest entry on ties.
            top = 0;
            for (int i = 1; i < held_keys.size(); i++) begin
              if (serve_largest ? (held_keys[i] > held_keys[top])
                                : (held_keys[i] < held_keys[top])) begin
                top = i;
              end
            end
            r.key = held_keys[top];
            if (cmd == CMD_REMOVE) begin
              held_keys.delete(top);
            end
          end
        end
        default: begin
        end
      endcase
      r.count = CNT_IO_W'(held_keys.size());
      expected_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected word: key %h status %0d count %0d",
                   got.key, got.status, got.count);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (got.key !== want.key || got.status !== want.status ||
          got.count !== want.count) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected key %h status %0d count %0d, got key %h status %0d count %0d",
                   want.key, want.status, want.count, got.key, got.status, got.count);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          cmd_i;
  logic [KEY_IO_W-1:0] key_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [KEY_IO_W-1:0] key_out_o;
  logic [1:0]          status_o;
  logic [CNT_IO_W-1:0] count_o;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CAP_W-1:0]    cfg_wdata_i;

  queue_scoreboard sb = new();
  bit              calm;
  bit              hold_req;

  array_priority_queue_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_in_i    (key_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_out_o   (key_out_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Offers one word, at times after a random burst of idle cycles, and
  // returns at the edge where it is taken.
  task automatic send_command(logic [1:0] cmd, logic [KEY_IO_W-1:0] key);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      cmd_i      = 2'($urandom);
      key_in_i   = $urandom;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    key_in_i   = key;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, key);
  endtask

  task automatic settle(int extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CAP_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.note_config(idx, data);
  endtask

  function automatic logic [KEY_IO_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_IO_W'($urandom_range(0, 7));
      5:       return {1'b1, 31'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reply(reply_t'{key: key_out_o, status: status_o, count: count_o});
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i = 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(1, 10) - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    #15ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    bit          mode_list[10];
    int unsigned cap_list[10];
    int          held;
    int          roll;
    int          n_items;
    logic [1:0]  c;
    bit          filling;

    mode_list = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
    cap_list  = '{10, 1, 64, 127, 0, 3, 100, 64, 5, 20};
    filling   = 1'b1;

    in_valid_i  = 1'b0;
    cmd_i       = CMD_INSERT;
    key_in_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_HIGH_MODE;
    cfg_wdata_i = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue, then ties at both key extremes under the reset settings.
    send_command(CMD_REMOVE, '1);
    send_command(CMD_PEEK, '0);
    send_command(CMD_UNUSED, 32'h1234_5678);
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, '1);
    send_command(CMD_INSERT, 32'd5);
    send_command(CMD_INSERT, '1);
    send_command(CMD_INSERT, '0);
    send_command(CMD_PEEK, '0);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_PEEK, '0);
    send_command(CMD_UNUSED, '1);
    settle(4);
    write_reg(CFG_HIGH_MODE, '0);
    send_command(CMD_PEEK, '0);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_REMOVE, '0);
    settle(4);
    // A zero limit refuses everything; a limit below the count drops nothing.
    write_reg(CFG_CAP_LIMIT, '0);
    send_command(CMD_INSERT, 32'd9);
    settle(4);
    write_reg(CFG_CAP_LIMIT, 7'd127);
    send_command(CMD_INSERT, 32'd7);
    settle(4);
    write_reg(CFG_CAP_LIMIT, 7'd1);
    send_command(CMD_INSERT, 32'd3);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_REMOVE, '0);

    for (int p = 0; p < 10; p++) begin
      settle(4);
      write_reg(CFG_HIGH_MODE, {6'($urandom_range(0, 63)), mode_list[p]});
      write_reg(CFG_CAP_LIMIT, 7'(cap_list[p]));
      calm = (p == 5 || p == 9);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      n_items = (cap_list[p] >= QUEUE_DEPTH) ? 300 : 150;
      for (int n = 0; n < n_items; n++) begin
        // Run the queue up to its limit and back down to empty in turns.
        held = sb.held_keys.size();
        if (filling && held >= sb.room() && $urandom_range(0, 3) == 0) begin
          filling = 1'b0;
        end else if (!filling && held == 0 && $urandom_range(0, 3) == 0) begin
          filling = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          c = CMD_UNUSED;
        end else if (roll < 15) begin
          c = CMD_PEEK;
        end else if (roll < (filling ? 75 : 35)) begin
          c = CMD_INSERT;
        end else begin
          c = CMD_REMOVE;
        end
        send_command(c, pick_key());
      end
    end

    settle(DRAIN_WAIT);
    if (sb.failures == 0 && sb.expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/apq_pkg.sv
sv/apq_ram.sv
sv/array_priority_queue_unit.sv
sim/testbench.sv
